// ----- rtl/core/pmfg_pkg.sv -----
// pmfg_pkg: shared widths, codes and structures of the point mass field grid.
// Depends on nothing. Imported by every module under rtl/core.
package pmfg_pkg;

   localparam int MAX_POINTS    = 16;
   localparam int GRID_DIM_BITS = 8;

   localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int SIZE_W  = GRID_DIM_BITS + 1;
   localparam int ACT_W   = 5;
   localparam int MODE_W  = 2;
   localparam int PIDX_W  = 4;
   localparam int LPOS_W  = 17;
   localparam int MASS_W  = 16;
   localparam int STEP_W  = 16;
   localparam int POS_W   = 18;
   localparam int LEVEL_W = 17;
   localparam int FRAC_W  = 16;
   localparam int CSR_IDX_W = 2;

   // offsets in Q.16 dots, magnitudes in Q.8 dots
   localparam int DX_W    = POS_W + SIZE_W + 1;
   localparam int AX_W    = DX_W - 8;
   localparam int D2_W    = 2 * AX_W + 1;
   localparam int ROOT_W  = (D2_W + 1) / 2;
   localparam int SQ_IN_W = 2 * ROOT_W;
   localparam int AREA_W  = 2 * SIZE_W;
   localparam int NUM_W   = MASS_W + AREA_W + FRAC_W;
   localparam int Q_W     = 25;
   localparam int DEN_W   = D2_W;
   localparam int ACC_W   = Q_W + IDX_W + 1;
   localparam int MUL_W   = ACC_W + 1;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int S_W     = 2 * ACC_W - 1;

   localparam int ONE_Q16 = 65536;
   localparam logic [Q_W-1:0] STRENGTH_CAP = {1'b1, {(Q_W-1){1'b0}}};

   localparam logic [MODE_W-1:0] MODE_EVAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]        op;
      logic [GRID_DIM_BITS-1:0] grid_x;
      logic [GRID_DIM_BITS-1:0] grid_y;
      logic [IDX_W-1:0]         point_index;
      logic [LPOS_W-1:0]        pos_x;
      logic [LPOS_W-1:0]        pos_y;
      logic [MASS_W-1:0]        mass;
      logic signed [STEP_W-1:0] step_x;
      logic signed [STEP_W-1:0] step_y;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0]  active_points;
      logic [SIZE_W-1:0] grid_width;
      logic [SIZE_W-1:0] grid_height;
   } cfg_type;

endpackage

// ----- rtl/core/pmfg_div.sv -----
// pmfg_div: restoring divider, one quotient bit a cycle, with overflow flag.
// Depends on pmfg_pkg.
module pmfg_div import pmfg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [Q_W-1:0]   quo,
   output logic             ovf
);

   localparam int QC_W = $clog2(Q_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [Q_W-1:0]   lo_ff, lo_in;
   logic [QC_W-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in, ovf_ff, ovf_in;
   logic [DEN_W:0]   cur, diff;
   logic             ge;

   always_comb begin
      cur    = {rem_ff, lo_ff[Q_W-1]};
      ge     = cur >= {1'b0, den_ff};
      diff   = cur - {1'b0, den_ff};
      rem_in = rem_ff;
      lo_in  = lo_ff;
      den_in = den_ff;
      ovf_in = ovf_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = DEN_W'(num[NUM_W-1:Q_W]);
         lo_in  = num[Q_W-1:0];
         den_in = den;
         ovf_in = DEN_W'(num[NUM_W-1:Q_W]) >= den;
         cnt_in = QC_W'(Q_W);
      end else if (busy_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
         lo_in  = {lo_ff[Q_W-2:0], ge};
         cnt_in = cnt_ff - QC_W'(1);
      end
      busy_in = cnt_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      den_ff <= den_in;
      ovf_ff <= ovf_in;
   end

   assign busy = busy_ff;
   assign quo  = lo_ff;
   assign ovf  = ovf_ff;

endmodule

// ----- rtl/core/pmfg_sqrt.sv -----
// pmfg_sqrt: digit-by-digit integer square root, one root bit a cycle.
// Depends on pmfg_pkg.
module pmfg_sqrt import pmfg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SQ_IN_W-1:0] rad,
   output logic               busy,
   output logic [ROOT_W-1:0]  root
);

   localparam int REM_W = ROOT_W + 2;
   localparam int RC_W  = $clog2(ROOT_W + 1);

   logic [SQ_IN_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [RC_W-1:0]    cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [REM_W+1:0]   cur, trial, diff;
   logic               ge;

   always_comb begin
      cur     = {rem_ff, rad_ff[SQ_IN_W-1 -: 2]};
      trial   = (REM_W+2)'({root_ff, 2'b01});
      ge      = cur >= trial;
      diff    = cur - trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rad_in  = rad;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = RC_W'(ROOT_W);
      end else if (busy_ff) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - RC_W'(1);
      end
      busy_in = cnt_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

// ----- rtl/core/pmfg_front.sv -----
// pmfg_front: accepts request transactions, classifies them and queues commands.
// Depends on pmfg_pkg.
module pmfg_front import pmfg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [GRID_DIM_BITS-1:0] req_grid_x,
   input  logic [GRID_DIM_BITS-1:0] req_grid_y,
   input  logic [PIDX_W-1:0]        req_point_index,
   input  logic [LPOS_W-1:0]        req_load_pos_x,
   input  logic [LPOS_W-1:0]        req_load_pos_y,
   input  logic [MASS_W-1:0]        req_load_mass,
   input  logic signed [STEP_W-1:0] req_load_step_x,
   input  logic signed [STEP_W-1:0] req_load_step_y,
   output cmd_type                  cmd,
   output logic                     cmd_valid,
   input  logic                     cmd_ready
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep, push, pop;
   cmd_type    cmd_new;

   // unused mode and out-of-table loads are taken and dropped
   always_comb begin
      unique case (req_mode)
         MODE_EVAL, MODE_TICK: keep = 1'b1;
         MODE_LOAD:            keep = 32'(req_point_index) < MAX_POINTS;
         default:              keep = 1'b0;
      endcase
   end

   always_comb begin
      cmd_new.op          = req_mode;
      cmd_new.grid_x      = req_grid_x;
      cmd_new.grid_y      = req_grid_y;
      cmd_new.point_index = IDX_W'(req_point_index);
      cmd_new.pos_x       = req_load_pos_x;
      cmd_new.pos_y       = req_load_pos_y;
      cmd_new.mass        = req_load_mass;
      cmd_new.step_x      = req_load_step_x;
      cmd_new.step_y      = req_load_step_y;
   end

   assign req_ready = cnt_ff != 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && keep;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- rtl/core/pmfg_back.sv -----
// pmfg_back: point table, tick sweep and field evaluation sequencer.
// Depends on pmfg_pkg, pmfg_div and pmfg_sqrt.
module pmfg_back import pmfg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_dot_level
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] S_IDLE = 5'd0,  S_TICK = 5'd1,  S_AREA = 5'd2,
                               S_PX   = 5'd3,  S_PY   = 5'd4,  S_DY   = 5'd5,
                               S_SQX  = 5'd6,  S_SQY  = 5'd7,  S_D2   = 5'd8,
                               S_MASS = 5'd9,  S_NUM  = 5'd10, S_DIVG = 5'd11,
                               S_GX   = 5'd12, S_CX   = 5'd13, S_DIVX = 5'd14,
                               S_CY   = 5'd15, S_DIVY = 5'd16, S_FX   = 5'd17,
                               S_FY   = 5'd18, S_FS   = 5'd19, S_FR   = 5'd20,
                               S_FQ   = 5'd21, S_OUT  = 5'd22;
   localparam logic signed [POS_W-1:0] POS_ONE = POS_W'(ONE_Q16);

   logic signed [POS_W-1:0]  pos_x_ff [MAX_POINTS];
   logic signed [POS_W-1:0]  pos_y_ff [MAX_POINTS];
   logic [MASS_W-1:0]        mass_ff  [MAX_POINTS];
   logic signed [STEP_W-1:0] step_x_ff [MAX_POINTS];
   logic signed [STEP_W-1:0] step_y_ff [MAX_POINTS];

   logic [ST_W-1:0]          state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [GRID_DIM_BITS-1:0] gpx_ff, gpx_in, gpy_ff, gpy_in;
   logic [AREA_W-1:0]        area_ff, area_in;
   logic signed [DX_W-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [D2_W-1:0]          d2_ff, d2_in;
   logic [Q_W-1:0]           g_ff, g_in;
   logic [ROOT_W-1:0]        d_ff, d_in;
   logic signed [ACC_W-1:0]  accx_ff, accx_in, accy_ff, accy_in;
   logic [S_W-1:0]           s_ff, s_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]       rsp_level_ff, rsp_level_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic                     sq_start, sq_busy, div_start, div_busy, div_ovf;
   logic [SQ_IN_W-1:0]       sq_rad;
   logic [ROOT_W-1:0]        sq_root;
   logic [NUM_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic [Q_W-1:0]           div_quo;

   logic [DX_W-1:0]          dx_mag, dy_mag;
   logic [AX_W-1:0]          ax, ay;
   logic [ACC_W-1:0]         mx, my;
   logic                     last;
   logic                     ld_we, mv_we;
   logic signed [POS_W-1:0]  cur_px, cur_py, new_px, new_py;
   logic signed [STEP_W-1:0] cur_sx, cur_sy, new_sx, new_sy;
   logic                     flip_x, flip_y;

   pmfg_sqrt u_sqrt (
      .clock (clock), .reset (reset), .start (sq_start), .rad (sq_rad),
      .busy  (sq_busy), .root (sq_root)
   );

   pmfg_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .num (div_num),
      .den   (div_den), .busy (div_busy), .quo (div_quo), .ovf (div_ovf)
   );

   always_comb begin
      dx_mag = dx_ff[DX_W-1] ? DX_W'(-dx_ff) : DX_W'(dx_ff);
      dy_mag = dy_ff[DX_W-1] ? DX_W'(-dy_ff) : DX_W'(dy_ff);
      ax     = dx_mag[DX_W-1:8];
      ay     = dy_mag[DX_W-1:8];
      mx     = accx_ff[ACC_W-1] ? ACC_W'(-accx_ff) : ACC_W'(accx_ff);
      my     = accy_ff[ACC_W-1] ? ACC_W'(-accy_ff) : ACC_W'(accy_ff);
      last   = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;

      // bounce: negate the step at or beyond either edge, then move
      cur_px = pos_x_ff[idx_ff];
      cur_py = pos_y_ff[idx_ff];
      cur_sx = step_x_ff[idx_ff];
      cur_sy = step_y_ff[idx_ff];
      flip_x = (cur_px >= POS_ONE) || cur_px[POS_W-1] || (cur_px == '0);
      flip_y = (cur_py >= POS_ONE) || cur_py[POS_W-1] || (cur_py == '0);
      new_sx = flip_x ? STEP_W'(-cur_sx) : cur_sx;
      new_sy = flip_y ? STEP_W'(-cur_sy) : cur_sy;
      new_px = POS_W'(cur_px + POS_W'(new_sx));
      new_py = POS_W'(cur_py + POS_W'(new_sy));
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      gpx_in       = gpx_ff;
      gpy_in       = gpy_ff;
      area_in      = area_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      d2_in        = d2_ff;
      g_in         = g_ff;
      d_in         = d_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      s_in         = s_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_level_in = rsp_level_ff;
      cmd_ready    = 1'b0;
      ld_we        = 1'b0;
      mv_we        = 1'b0;
      mul_a        = $signed(MUL_W'(cfg.grid_width));
      mul_b        = $signed(MUL_W'(cfg.grid_height));
      sq_start     = 1'b0;
      sq_rad       = SQ_IN_W'(d2_ff);
      div_start    = 1'b0;
      div_num      = {prod_ff[MASS_W+AREA_W-1:0], {FRAC_W{1'b0}}};
      div_den      = d2_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            n_in = (32'(cfg.active_points) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                         : CNT_W'(cfg.active_points);
            idx_in = '0;
            if (cmd_valid) begin
               unique case (cmd.op)
                  MODE_LOAD: ld_we = 1'b1;
                  MODE_TICK: state_in = (n_in == '0) ? S_IDLE : S_TICK;
                  default: begin
                     gpx_in   = cmd.grid_x;
                     gpy_in   = cmd.grid_y;
                     accx_in  = '0;
                     accy_in  = '0;
                     state_in = S_AREA;
                  end
               endcase
            end
         end
         S_TICK: begin
            mv_we  = 1'b1;
            idx_in = idx_ff + IDX_W'(1);
            if (last) state_in = S_IDLE;
         end
         S_AREA: begin
            area_in  = prod_ff[AREA_W-1:0];
            state_in = (n_ff == '0) ? S_FX : S_PX;
         end
         S_PX: begin
            mul_a    = MUL_W'(pos_x_ff[idx_ff]);
            mul_b    = $signed(MUL_W'(cfg.grid_width));
            state_in = S_PY;
         end
         S_PY: begin
            dx_in    = $signed(DX_W'({gpx_ff, {FRAC_W{1'b0}}})) - $signed(prod_ff[DX_W-1:0]);
            mul_a    = MUL_W'(pos_y_ff[idx_ff]);
            mul_b    = $signed(MUL_W'(cfg.grid_height));
            state_in = S_DY;
         end
         S_DY: begin
            dy_in    = $signed(DX_W'({gpy_ff, {FRAC_W{1'b0}}})) - $signed(prod_ff[DX_W-1:0]);
            state_in = S_SQX;
         end
         S_SQX: begin
            mul_a    = $signed(MUL_W'(ax));
            mul_b    = $signed(MUL_W'(ax));
            state_in = S_SQY;
         end
         S_SQY: begin
            d2_in    = prod_ff[D2_W-1:0];
            mul_a    = $signed(MUL_W'(ay));
            mul_b    = $signed(MUL_W'(ay));
            state_in = S_D2;
         end
         S_D2: begin
            d2_in    = d2_ff + prod_ff[D2_W-1:0];
            state_in = S_MASS;
         end
         S_MASS: begin
            mul_a = $signed(MUL_W'(mass_ff[idx_ff]));
            mul_b = $signed(MUL_W'(area_ff));
            if (d2_ff == '0) begin
               // point sits on the dot: no contribution
               idx_in   = idx_ff + IDX_W'(1);
               state_in = last ? S_FX : S_PX;
            end else begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            div_start = 1'b1;
            sq_start  = 1'b1;
            state_in  = S_DIVG;
         end
         S_DIVG: begin
            if (!div_busy && !sq_busy) begin
               g_in     = (div_ovf || div_quo > STRENGTH_CAP) ? STRENGTH_CAP : div_quo;
               d_in     = sq_root;
               state_in = S_GX;
            end
         end
         S_GX: begin
            mul_a    = $signed(MUL_W'(g_ff));
            mul_b    = $signed(MUL_W'(ax));
            state_in = S_CX;
         end
         S_CX: begin
            div_start = 1'b1;
            div_num   = NUM_W'(prod_ff[Q_W+AX_W-1:0]);
            div_den   = DEN_W'(d_ff);
            state_in  = S_DIVX;
         end
         S_DIVX: begin
            mul_a = $signed(MUL_W'(g_ff));
            mul_b = $signed(MUL_W'(ay));
            if (!div_busy) begin
               accx_in  = dx_ff[DX_W-1] ? accx_ff - $signed(ACC_W'(div_quo))
                                        : accx_ff + $signed(ACC_W'(div_quo));
               state_in = S_CY;
            end
         end
         S_CY: begin
            div_start = 1'b1;
            div_num   = NUM_W'(prod_ff[Q_W+AX_W-1:0]);
            div_den   = DEN_W'(d_ff);
            state_in  = S_DIVY;
         end
         S_DIVY: begin
            if (!div_busy) begin
               accy_in  = dy_ff[DX_W-1] ? accy_ff - $signed(ACC_W'(div_quo))
                                        : accy_ff + $signed(ACC_W'(div_quo));
               idx_in   = idx_ff + IDX_W'(1);
               state_in = last ? S_FX : S_PX;
            end
         end
         S_FX: begin
            mul_a    = $signed(MUL_W'(mx));
            mul_b    = $signed(MUL_W'(mx));
            state_in = S_FY;
         end
         S_FY: begin
            s_in     = prod_ff[S_W-1:0];
            mul_a    = $signed(MUL_W'(my));
            mul_b    = $signed(MUL_W'(my));
            state_in = S_FS;
         end
         S_FS: begin
            s_in     = s_ff + prod_ff[S_W-1:0];
            state_in = S_FR;
         end
         S_FR: begin
            sq_rad = SQ_IN_W'(s_ff[2*FRAC_W-1:0]);
            if (|s_ff[S_W-1:2*FRAC_W]) begin
               level_in = LEVEL_W'(ONE_Q16);
               state_in = S_OUT;
            end else begin
               sq_start = 1'b1;
               state_in = S_FQ;
            end
         end
         S_FQ: begin
            if (!sq_busy) begin
               level_in = sq_root[LEVEL_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = level_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_POINTS; i++) begin
            pos_x_ff[i]  <= '0;
            pos_y_ff[i]  <= '0;
            mass_ff[i]   <= '0;
            step_x_ff[i] <= '0;
            step_y_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ld_we) begin
            pos_x_ff[cmd.point_index]  <= POS_W'(cmd.pos_x);
            pos_y_ff[cmd.point_index]  <= POS_W'(cmd.pos_y);
            mass_ff[cmd.point_index]   <= cmd.mass;
            step_x_ff[cmd.point_index] <= cmd.step_x;
            step_y_ff[cmd.point_index] <= cmd.step_y;
         end
         if (mv_we) begin
            pos_x_ff[idx_ff]  <= new_px;
            pos_y_ff[idx_ff]  <= new_py;
            step_x_ff[idx_ff] <= new_sx;
            step_y_ff[idx_ff] <= new_sy;
         end
      end
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      gpx_ff       <= gpx_in;
      gpy_ff       <= gpy_in;
      area_ff      <= area_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      d2_ff        <= d2_in;
      g_ff         <= g_in;
      d_ff         <= d_in;
      accx_ff      <= accx_in;
      accy_ff      <= accy_in;
      s_ff         <= s_in;
      level_ff     <= level_in;
      rsp_level_ff <= rsp_level_in;
      prod_ff      <= mul_a * mul_b;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dot_level = rsp_level_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PX) |-> (CNT_W'(idx_ff) < n_ff))
      else $error("point index beyond active count");
   a_level_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= LEVEL_W'(ONE_Q16)))
      else $error("dot level above 1.0");
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> !sq_busy)
      else $error("root unit started while busy");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");
   a_strength_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GX) |-> (g_ff <= STRENGTH_CAP))
      else $error("strength above cap");

endmodule

// ----- rtl/core/point_mass_field_grid_top.sv -----
// point_mass_field_grid_top: top level, configuration registers and wiring.
// Depends on pmfg_pkg, pmfg_front and pmfg_back.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | mode, grid x/y, point index, load fields
//  rsp     | out | rsp_valid/rsp_ready | dot_level (Q1.16, 65536 is 1.0)
//  csr     | in  | csr_valid/csr_ready | csr_index, csr_wdata
//
// Loads are written to the table from the idle state; a tick sweeps the table
// one point a cycle. An evaluate first forms the grid area, then per point runs
// multiplies and three divides on the single shared divider (the root runs
// beside the first), and it ends with a final root.
// Reset is synchronous; it clears the table, queue and sequencer and sets the registers to their defaults.
// A two-entry command queue parts the request side from the sequencer, and the
// result register lets the next transaction start while a result waits.
module point_mass_field_grid_top import pmfg_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [MODE_W-1:0]        req_mode,
   input  logic [GRID_DIM_BITS-1:0] req_grid_x,
   input  logic [GRID_DIM_BITS-1:0] req_grid_y,
   input  logic [PIDX_W-1:0]        req_point_index,
   input  logic [LPOS_W-1:0]        req_load_pos_x,
   input  logic [LPOS_W-1:0]        req_load_pos_y,
   input  logic [MASS_W-1:0]        req_load_mass,
   input  logic signed [STEP_W-1:0] req_load_step_x,
   input  logic signed [STEP_W-1:0] req_load_step_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [LEVEL_W-1:0]       rsp_dot_level,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [SIZE_W-1:0]        csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   // registers are always writable and take effect at once; write only while idle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACTIVE: cfg_in.active_points = csr_wdata[ACT_W-1:0];
            CSR_WIDTH:  cfg_in.grid_width    = csr_wdata;
            CSR_HEIGHT: cfg_in.grid_height   = csr_wdata;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_points <= ACT_W'(10);
         cfg_ff.grid_width    <= SIZE_W'(64);
         cfg_ff.grid_height   <= SIZE_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pmfg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_grid_x      (req_grid_x),
      .req_grid_y      (req_grid_y),
      .req_point_index (req_point_index),
      .req_load_pos_x  (req_load_pos_x),
      .req_load_pos_y  (req_load_pos_y),
      .req_load_mass   (req_load_mass),
      .req_load_step_x (req_load_step_x),
      .req_load_step_y (req_load_step_y),
      .cmd             (cmd),
      .cmd_valid       (cmd_valid),
      .cmd_ready       (cmd_ready)
   );

   pmfg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (cmd),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dot_level (rsp_dot_level)
   );

endmodule
